@@ src/url_percent_decoder_macros.svh @@
// url_percent_decoder_macros.svh: assertion macros for the decoder blocks
// no dependencies; included by modules that carry assertions
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// property that must hold on every clock edge outside reset
`define UPD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the same cycle
`define UPD_ASSERT_IMPL(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// implication checked in the following cycle
`define UPD_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ src/upd_pkg.sv @@
// upd_pkg: types, constants and the hex digit helper of the url decoder
// no dependencies; used by every decoder module
package upd_pkg;

  localparam logic [7:0]  CHAR_PERCENT = 8'h25;
  localparam logic [7:0]  CHAR_PLUS    = 8'h2B;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [7:0]  CHAR_NUL     = 8'h00;
  localparam logic [15:0] LIMIT_RESET  = 16'hFFFF;
  localparam int          QUEUE_DEPTH_DEF = 2;
  localparam int          MAX_RESULTS  = 3;

  // one raw input byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  // one decoded result
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        done_res;
    logic [15:0] total_count;
  } out_item_t;

  // classified work for the back end: candidate bytes in order
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  cnt;
    logic                        last;
  } op_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // escape hold state
  typedef enum logic [2:0] {
    HOLD_NONE  = 3'b001,
    HOLD_PCT   = 3'b010,
    HOLD_DIGIT = 3'b100
  } hold_t;

  function automatic hex_t hex_check(input logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      h.ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      h.ok = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      h.ok = 1'b1;
    end
    h.val = d[3:0];
    return h;
  endfunction

endpackage

@@ src/upd_front.sv @@
// upd_front: escape tracking and classification of raw bytes into candidate output bytes
// depends on upd_pkg
module upd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  upd_pkg::in_item_t item,
  output upd_pkg::op_t      op,
  output logic              op_needed
);
  import upd_pkg::*;

  hold_t      hold, hold_next;
  logic [7:0] digit, digit_next;
  logic       stopped, stopped_next;

  logic [7:0] c;
  hex_t       hc, hd;
  logic [1:0] n;

  assign c  = item.in_byte;
  assign hc = hex_check(c);
  assign hd = hex_check(digit);

  // step the escape state and collect the bytes it releases
  always_comb begin
    op           = '0;
    n            = '0;
    hold_next    = hold;
    digit_next   = digit;
    stopped_next = stopped;
    if (!stopped) begin
      if (c == CHAR_NUL) begin
        if (hold != HOLD_NONE) begin
          op.bytes[n] = CHAR_PERCENT;
          n = n + 2'd1;
        end
        if (hold == HOLD_DIGIT) begin
          op.bytes[n] = digit;
          n = n + 2'd1;
        end
        hold_next    = HOLD_NONE;
        stopped_next = 1'b1;
      end else begin
        unique case (hold)
          HOLD_NONE: begin
            if (c == CHAR_PERCENT) begin
              hold_next = HOLD_PCT;
            end else begin
              op.bytes[n] = (c == CHAR_PLUS) ? CHAR_SPACE : c;
              n = n + 2'd1;
            end
          end
          HOLD_PCT: begin
            if (hc.ok) begin
              digit_next = c;
              hold_next  = HOLD_DIGIT;
            end else begin
              op.bytes[n] = CHAR_PERCENT;
              n = n + 2'd1;
              if (c == CHAR_PERCENT) begin
                hold_next = HOLD_PCT;
              end else begin
                hold_next   = HOLD_NONE;
                op.bytes[n] = (c == CHAR_PLUS) ? CHAR_SPACE : c;
                n = n + 2'd1;
              end
            end
          end
          HOLD_DIGIT: begin
            if (hc.ok && hd.ok) begin
              hold_next   = HOLD_NONE;
              op.bytes[n] = {hd.val, hc.val};
              n = n + 2'd1;
            end else begin
              op.bytes[n] = CHAR_PERCENT;
              n = n + 2'd1;
              op.bytes[n] = digit;
              n = n + 2'd1;
              if (c == CHAR_PERCENT) begin
                hold_next = HOLD_PCT;
              end else begin
                hold_next   = HOLD_NONE;
                op.bytes[n] = (c == CHAR_PLUS) ? CHAR_SPACE : c;
                n = n + 2'd1;
              end
            end
          end
          default: begin
            hold_next = HOLD_NONE;
          end
        endcase
      end
    end
    // end of string flushes whatever is still held
    if (item.last) begin
      if (hold_next != HOLD_NONE) begin
        op.bytes[n] = CHAR_PERCENT;
        n = n + 2'd1;
      end
      if (hold_next == HOLD_DIGIT) begin
        op.bytes[n] = digit_next;
        n = n + 2'd1;
      end
      hold_next    = HOLD_NONE;
      stopped_next = 1'b0;
    end
    op.cnt  = n;
    op.last = item.last;
  end

  // only entries that lead to a result or close a string go to the queue
  assign op_needed = (op.cnt != 2'd0) || op.last;

  // state update on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      hold    <= HOLD_NONE;
      stopped <= 1'b0;
    end else if (take) begin
      hold    <= hold_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      digit <= digit_next;
    end
  end

endmodule

@@ src/upd_fifo.sv @@
// upd_fifo: short queue of classified entries between front and back end
// depends on upd_pkg
module upd_fifo #(
  parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  upd_pkg::op_t wr_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output upd_pkg::op_t head_op
);
  import upd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] cnt;

  assign full       = (cnt == CW'(DEPTH));
  assign head_valid = (cnt != '0);
  assign head_op    = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

@@ src/upd_back.sv @@
// upd_back: applies the output limit, counts bytes and drives the result register
// depends on upd_pkg and url_percent_decoder_macros.svh
`include "url_percent_decoder_macros.svh"
module upd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               head_valid,
  input  upd_pkg::op_t       head_op,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output upd_pkg::out_item_t out_item
);
  import upd_pkg::*;

  logic [15:0] limit;
  logic [15:0] count, count_next, count_inc;
  logic [1:0]  idx, idx_next;
  logic        out_free, fire, none_left, final_one, emit;
  out_item_t   res;

  assign out_free  = !out_valid || out_ready;
  assign fire      = head_valid && out_free;
  assign count_inc = count + 16'd1;
  assign none_left = (head_op.cnt == 2'd0) || (count >= limit);
  assign final_one = (idx == head_op.cnt - 2'd1) || (count_inc == limit);

  // one result per cycle from the head entry while the output register is free
  always_comb begin
    res        = '0;
    emit       = 1'b0;
    pop        = 1'b0;
    idx_next   = idx;
    count_next = count;
    if (fire) begin
      if (none_left) begin
        pop      = 1'b1;
        idx_next = '0;
        if (head_op.last) begin
          emit            = 1'b1;
          res.done_res    = 1'b1;
          res.total_count = count;
          count_next      = '0;
        end
      end else begin
        emit         = 1'b1;
        res.out_byte = head_op.bytes[idx];
        res.has_byte = 1'b1;
        count_next   = count_inc;
        if (final_one) begin
          pop      = 1'b1;
          idx_next = '0;
          if (head_op.last) begin
            res.done_res    = 1'b1;
            res.total_count = count_inc;
            count_next      = '0;
          end
        end else begin
          idx_next = idx + 2'd1;
        end
      end
    end
  end

  // limit register, count and position within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIMIT_RESET;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      count <= count_next;
      idx   <= idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= res;
    end
  end

  `UPD_ASSERT_IMPL(a_done_within_limit, clk, rst, out_valid && out_item.done_res, out_item.total_count <= limit, "total count above limit")
  `UPD_ASSERT_IMPL(a_empty_is_done, clk, rst, out_valid && !out_item.has_byte, out_item.done_res && out_item.out_byte == 8'd0, "empty result without done")
  `UPD_ASSERT_IMPL(a_idx_needs_head, clk, rst, idx != 2'd0, head_valid && idx < head_op.cnt, "position past head entry")
  `UPD_ASSERT_NEXT(a_done_clears_count, clk, rst, emit && res.done_res, count == 16'd0, "count kept after string end")

endmodule

@@ src/url_percent_decoder.sv @@
// url_percent_decoder: top level of the streaming url decoder
// depends on upd_pkg, upd_front, upd_fifo, upd_back
//
//  channel  | signals                    | direction | payload
//  ---------+----------------------------+-----------+---------------------------------------
//  input    | in_valid / in_ready        | in        | in_item: in_byte, last
//  output   | out_valid / out_ready      | out       | out_item: out_byte, has_byte, done_res, total_count
//  config   | cfg_we                     | in        | cfg_wdata: output limit
//
// an item that releases several results holds the back end until all of them are out,
// one result per cycle through the result register while the output side is ready
// an input transfer reaches its result through the queue entry and then the result register
// the queue of QUEUE_DEPTH entries lets the front keep taking bytes while the back end waits
// reset is synchronous: escape state, counts and queue clear, limit returns to 65535
module url_percent_decoder #(
  parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  upd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output upd_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import upd_pkg::*;

  logic take, full, op_needed, pop, head_valid;
  op_t  op, head_op;

  // input transfer whenever the queue has room
  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_item),
    .op        (op),
    .op_needed (op_needed)
  );

  upd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (take && op_needed),
    .wr_op      (op),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

@@ sim/url_percent_decoder_checker.sv @@
// url_percent_decoder_checker: watches the input, output and config ports of the decoder
// and predicts every decoded result; depends on upd_pkg for the payload types and constants
module url_percent_decoder_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  upd_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  upd_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  import upd_pkg::*;

  // predicted decoder state
  hold_t       esc_state;
  logic [7:0]  esc_digit;
  logic [15:0] emitted;
  logic        ended;
  logic [15:0] byte_limit;
  int          err_n;

  // results of the byte being decoded, then all results still owed by the block
  out_item_t   step_q[$];
  out_item_t   decoded_q[$];

  // value of a hex digit character, -1 if it is not one
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  // one decoded byte, dropped once the limit is reached
  function automatic void emit_char(input logic [7:0] c);
    out_item_t r;
    if (emitted >= byte_limit || step_q.size() >= MAX_RESULTS) return;
    r = '0;
    r.out_byte = c;
    r.has_byte = 1'b1;
    step_q.push_back(r);
    emitted = emitted + 16'd1;
  endfunction

  // release a held percent sign and digit literally
  function automatic void flush_escape();
    if (esc_state != HOLD_NONE) emit_char(CHAR_PERCENT);
    if (esc_state == HOLD_DIGIT) emit_char(esc_digit);
    esc_state = HOLD_NONE;
    esc_digit = '0;
  endfunction

  function automatic void take_plain(input logic [7:0] c);
    if (c == CHAR_PERCENT) esc_state = HOLD_PCT;
    else emit_char(c == CHAR_PLUS ? CHAR_SPACE : c);
  endfunction

  function automatic void clear_string();
    esc_state = HOLD_NONE;
    esc_digit = '0;
    emitted   = '0;
    ended     = 1'b0;
  endfunction

  // decode one input transfer and queue what it releases
  function automatic void decode_step(input logic [7:0] c, input logic is_last);
    out_item_t r;
    int        lo;
    step_q.delete();
    lo = hex_digit(c);
    if (!ended) begin
      if (c == CHAR_NUL) begin
        flush_escape();
        ended = 1'b1;
      end else begin
        case (esc_state)
          HOLD_NONE: take_plain(c);
          HOLD_PCT: begin
            if (lo >= 0) begin
              esc_digit = c;
              esc_state = HOLD_DIGIT;
            end else begin
              flush_escape();
              take_plain(c);
            end
          end
          default: begin
            if (lo >= 0) begin
              emit_char({4'(hex_digit(esc_digit)), 4'(lo)});
              esc_state = HOLD_NONE;
              esc_digit = '0;
            end else begin
              flush_escape();
              take_plain(c);
            end
          end
        endcase
      end
    end
    // end of string: flush, mark the final result with the count
    if (is_last) begin
      flush_escape();
      if (step_q.size() == 0) r = '0;
      else r = step_q.pop_back();
      r.done_res    = 1'b1;
      r.total_count = emitted;
      step_q.push_back(r);
      clear_string();
    end
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      err_n++;
    end
  endfunction

  // sample all three ports on each edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      byte_limit = LIMIT_RESET;
      clear_string();
      decoded_q.delete();
      err_n = 0;
    end else begin
      if (cfg_we) byte_limit = cfg_wdata;
      if (in_valid && in_ready) decode_step(in_item.in_byte, in_item.last);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_item);
          err_n++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", 16'(want.out_byte), 16'(out_item.out_byte));
          check_field("has_byte", 16'(want.has_byte), 16'(out_item.has_byte));
          check_field("done_res", 16'(want.done_res), 16'(out_item.done_res));
          check_field("total_count", want.total_count, out_item.total_count);
        end
      end
    end
    fail_count <= err_n;
    pending    <= decoded_q.size();
  end

endmodule

@@ sim/url_percent_decoder_tb.sv @@
// url_percent_decoder_tb: drives byte strings and limit writes into the decoder
// depends on upd_pkg, url_percent_decoder and url_percent_decoder_checker
module url_percent_decoder_tb;

  import upd_pkg::*;

  localparam int N_PHASES       = 8;
  localparam int PHASE_BYTES    = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  int fail_count;
  int pending;
  int quiet_cycles;
  int bytes_sent;
  int strings_sent;
  int results_seen;
  int limits_set;
  int hold_req;
  bit tx_gaps;
  bit rx_stall;

  url_percent_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  url_percent_decoder_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : rx_side
    int stall;
    int holds_done;
    holds_done   = 0;
    results_seen = 0;
    out_ready    = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_stall ? $urandom_range(0, 10) : 0;
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        stall = 0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  // one byte transfer after a random gap; valid stays up across back-to-back bytes
  task automatic send_byte(input logic [7:0] c, input logic mark_last);
    in_item_t it;
    int       gap;
    it.in_byte = c;
    it.last    = mark_last;
    gap = tx_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (mark_last) strings_sent++;
  endtask

  task automatic send_text(input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], mark_last && i == s.len() - 1);
  endtask

  // stop sending and wait until every result is back and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // limit write, only while the decoder is idle
  task automatic set_limit(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limits_set++;
  endtask

  function automatic logic [7:0] rand_hex_char();
    int n;
    n = $urandom_range(0, 15);
    if (n < 10) return 8'(8'h30 + n);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 10);
  endfunction

  // anything that cannot follow a percent sign as a digit, the percent sign included
  function automatic logic [7:0] rand_non_hex();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(8'h01, 8'h2F));
      1: return 8'($urandom_range(8'h3A, 8'h40));
      2: return 8'($urandom_range(8'h47, 8'h60));
      3: return 8'($urandom_range(8'h67, 8'hFF));
      default: return CHAR_PERCENT;
    endcase
  endfunction

  // one string of mixed tokens, mostly well-formed escapes and text
  task automatic send_random_string(inout int count);
    logic [7:0] s[$];
    int         tokens;
    int         kind;
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        s.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (kind < 45) begin
        s.push_back(CHAR_PERCENT);
        s.push_back(rand_hex_char());
        s.push_back(rand_hex_char());
      end else if (kind < 55) begin
        s.push_back(CHAR_PLUS);
      end else if (kind < 65) begin
        s.push_back(CHAR_PERCENT);
        s.push_back(rand_non_hex());
      end else if (kind < 72) begin
        s.push_back(CHAR_PERCENT);
        s.push_back(rand_hex_char());
        s.push_back(rand_non_hex());
      end else if (kind < 76) begin
        s.push_back(CHAR_PERCENT);
      end else if (kind < 80) begin
        s.push_back(CHAR_NUL);
      end else begin
        s.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    count += s.size();
  endtask

  function automatic logic [15:0] phase_limit(input int ph);
    case (ph)
      0: return LIMIT_RESET;
      1: return 16'd5;
      2: return 16'd0;
      3: return 16'd1;
      4: return 16'($urandom_range(2, 12));
      5: return 16'h8000;
      6: return 16'($urandom_range(0, 65535));
      default: return 16'd3;
    endcase
  endfunction

  // stimulus and verdict
  initial begin : stim
    int phase_bytes;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    bytes_sent   = 0;
    strings_sent = 0;
    limits_set   = 0;
    hold_req     = 0;
    tx_gaps      = 1'b1;
    rx_stall     = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // escapes of both cases, plus, broken escapes, zero byte, byte extremes
    send_text("%4a", 1'b1);
    send_text("+%FF%", 1'b1);
    send_text("%G%4z", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_NUL, 1'b0);
    send_text("xy", 1'b1);
    send_text("%7", 1'b0);
    send_byte(CHAR_NUL, 1'b1);
    drain();
    // limit of zero, then a limit hit by a failed escape
    set_limit(16'd0);
    send_text("ab", 1'b1);
    drain();
    set_limit(16'd1);
    send_text("%zq", 1'b1);
    drain();

    // random strings under a different limit and idle pattern per phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_limit(phase_limit(ph));
      tx_gaps = (ph % 3 != 0);
      rx_stall <= (ph % 3 != 1);
      if (ph == 0) hold_req <= hold_req + 1;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_random_string(phase_bytes);
      drain();
    end

    $display("decoded %0d strings (%0d bytes) into %0d checked results",
             strings_sent, bytes_sent, results_seen);
    $display("%0d output limits from 0 to 65535, with gaps, stalls and a long hold-off",
             limits_set);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
